FILE: sv/mbt_pkg.sv
// Shared types, sizes and codes of the maze backtracker.
package mbt_pkg;

  // Store geometry.
  localparam int MaxWidth   = 32;
  localparam int MaxHeight  = 32;
  localparam int StackDepth = 1024;

  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int CellAw    = XW + YW;
  localparam int CellCount = MaxWidth * MaxHeight;
  localparam int StackAw   = $clog2(StackDepth);
  localparam int TopW      = StackAw + 1;
  localparam int CountW    = $clog2(CellCount + 1);

  // Field and register widths.
  localparam int CoordW = 5;
  localparam int CfgW   = 6;
  localparam int DimW   = CfgW + 1;

  localparam logic [CfgW-1:0] GridWidthReset  = CfgW'(20);
  localparam logic [CfgW-1:0] GridHeightReset = CfgW'(10);

  // Configuration register indexes.
  localparam logic RegGridWidth  = 1'b0;
  localparam logic RegGridHeight = 1'b1;

  typedef enum logic [1:0] {
    ActStart = 2'd0,
    ActStep  = 2'd1,
    ActRead  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KindStarted     = 3'd0,
    KindCarved      = 3'd1,
    KindBacktracked = 3'd2,
    KindFinished    = 3'd3,
    KindRead        = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    DirEast  = 2'd0,
    DirWest  = 2'd1,
    DirSouth = 2'd2,
    DirNorth = 2'd3
  } dir_e;

  // One cell word: visited mark above the passage bits (east in bit 0).
  typedef struct packed {
    logic       visited;
    logic [3:0] pass;
  } cell_t;

  // Passage bit opened in the cell we leave.
  function automatic logic [3:0] here_mask(dir_e d);
    logic [3:0] m;
    m = 4'b0001 << d;
    return m;
  endfunction

  // Passage bit opened in the cell we enter.
  function automatic logic [3:0] there_mask(dir_e d);
    logic [3:0] m;
    case (d)
      DirEast:  m = 4'b0010;
      DirWest:  m = 4'b0001;
      DirSouth: m = 4'b1000;
      DirNorth: m = 4'b0100;
      default:  m = 4'b0000;
    endcase
    return m;
  endfunction

  // Clamp a grid register to 1..max.
  function automatic logic [DimW-1:0] clamp_dim(logic [CfgW-1:0] v, int maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (DimW'(v) > DimW'(maxv)) begin
      r = DimW'(maxv);
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

endpackage

FILE: sv/maze_backtracker_step.sv
// Depth-first maze carver with cell store and path stack in synchronous RAMs.
//
//  channel   handshake             payload
//  config    cfg_we_i              cfg_addr_i, cfg_wdata_i
//  command   start_i / busy_o      action_i, cell_x_i, cell_y_i, choice_i
//  result    done_o (one cycle)    kind_o, pos_x_o, pos_y_o, direction_o,
//                                  passages_o, cell_visited_o, stack_overflow_o
//
// A command is taken when start_i is high and busy_o is low; one word at a time.
// A carving step makes five reads of the single-port cell RAM
// (four neighbors, then the current cell) and two writes. A backtrack makes
// the same five reads, a path stack read and a read of the cell it returns
// to; popping the last entry makes only the five reads. A read or a step on a
// finished or empty walk makes a single cell read. A start sweeps the cell
// RAM, one entry a cycle, then marks the start cell; the same sweep follows
// reset with busy_o high. Results cannot be held off by the receiver.
module maze_backtracker_step
  import mbt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        action_i,
  input  logic [CoordW-1:0] cell_x_i,
  input  logic [CoordW-1:0] cell_y_i,
  input  logic [1:0]        choice_i,
  output logic              done_o,
  output logic [2:0]        kind_o,
  output logic [CoordW-1:0] pos_x_o,
  output logic [CoordW-1:0] pos_y_o,
  output logic [1:0]        direction_o,
  output logic [3:0]        passages_o,
  output logic              cell_visited_o,
  output logic              stack_overflow_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_START,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CARVE,
    S_POP_RD,
    S_REPORT
  } state_e;

  state_e              state_q;
  logic                start_pend_q;
  logic [CellAw-1:0]   clr_cnt_q;
  logic [2:0]          rd_idx_q;
  cell_t               nbr_q [4];
  dir_e                choice_q;
  dir_e                dir_q;
  kind_e               rep_kind_q;
  logic [XW-1:0]       rep_x_q;
  logic [YW-1:0]       rep_y_q;
  logic [XW-1:0]       cur_x_q;
  logic [YW-1:0]       cur_y_q;
  logic [TopW-1:0]     top_q;
  logic [CountW-1:0]   count_q;
  logic [CfgW-1:0]     grid_w_q;
  logic [CfgW-1:0]     grid_h_q;

  logic                done_q;
  kind_e               kind_q;
  logic [CoordW-1:0]   pos_x_q;
  logic [CoordW-1:0]   pos_y_q;
  dir_e                out_dir_q;
  logic [3:0]          pass_q;
  logic                vis_q;
  logic                ovf_q;

  // Cell RAM port.
  cell_t               cell_mem [CellCount];
  logic                cell_we;
  logic [CellAw-1:0]   cell_addr;
  cell_t               cell_wdata;
  cell_t               cell_rdata_q;

  // Path stack RAM port.
  logic [CellAw-1:0]   stack_mem [StackDepth];
  logic                stack_we;
  logic [StackAw-1:0]  stack_addr;
  logic [CellAw-1:0]   stack_wdata;
  logic [CellAw-1:0]   stack_rdata_q;

  logic [DimW-1:0]     dim_w;
  logic [DimW-1:0]     dim_h;
  logic [CountW-1:0]   area;
  logic                finished;
  logic [XW-1:0]       start_x;
  logic [YW-1:0]       start_y;
  logic [CellAw-1:0]   cur_idx;
  logic [CellAw-1:0]   nbr_idx [4];
  logic [3:0]          in_grid;
  logic [3:0]          open_dir;
  logic                found;
  dir_e                pick;
  dir_e                cand;
  logic [TopW-1:0]     top_dec;
  logic [TopW-1:0]     top_dec2;
  logic                push_ok;
  logic [XW-1:0]       nx;
  logic [YW-1:0]       ny;
  logic [XW-1:0]       pop_x;
  logic [YW-1:0]       pop_y;
  logic                accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Grid size in use and the finished test.
  assign dim_w    = clamp_dim(grid_w_q, MaxWidth);
  assign dim_h    = clamp_dim(grid_h_q, MaxHeight);
  assign area     = CountW'(dim_w * dim_h);
  assign finished = (count_q >= area);

  // Start cell saturates to the last column and row.
  assign start_x = (DimW'(cell_x_i) < dim_w) ? XW'(cell_x_i) : XW'(dim_w - DimW'(1));
  assign start_y = (DimW'(cell_y_i) < dim_h) ? YW'(cell_y_i) : YW'(dim_h - DimW'(1));

  // Neighbor addresses in the order east, west, south, north.
  assign cur_idx    = {cur_y_q, cur_x_q};
  assign nbr_idx[0] = {cur_y_q, cur_x_q + XW'(1)};
  assign nbr_idx[1] = {cur_y_q, cur_x_q - XW'(1)};
  assign nbr_idx[2] = {cur_y_q + YW'(1), cur_x_q};
  assign nbr_idx[3] = {cur_y_q - YW'(1), cur_x_q};

  assign in_grid[0] = (DimW'(cur_x_q) + DimW'(1)) < dim_w;
  assign in_grid[1] = (cur_x_q != '0) && ((DimW'(cur_x_q) - DimW'(1)) < dim_w);
  assign in_grid[2] = (DimW'(cur_y_q) + DimW'(1)) < dim_h;
  assign in_grid[3] = (cur_y_q != '0) && ((DimW'(cur_y_q) - DimW'(1)) < dim_h);

  // First unvisited in-grid neighbor at or after the random choice.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      open_dir[k] = in_grid[k] && !nbr_q[k].visited;
    end
    found = 1'b0;
    pick  = DirEast;
    cand  = DirEast;
    for (int k = 0; k < 4; k++) begin
      cand = dir_e'(choice_q + 2'(k));
      if (!found && open_dir[cand]) begin
        found = 1'b1;
        pick  = cand;
      end
    end
  end

  // Cell the carve moves to.
  always_comb begin
    nx = cur_x_q;
    ny = cur_y_q;
    case (dir_q)
      DirEast:  nx = cur_x_q + XW'(1);
      DirWest:  nx = cur_x_q - XW'(1);
      DirSouth: ny = cur_y_q + YW'(1);
      DirNorth: ny = cur_y_q - YW'(1);
      default:  nx = cur_x_q;
    endcase
  end

  assign top_dec  = top_q - TopW'(1);
  assign top_dec2 = top_q - TopW'(2);
  assign push_ok  = (top_q < TopW'(StackDepth));
  assign pop_x    = stack_rdata_q[XW-1:0];
  assign pop_y    = stack_rdata_q[CellAw-1:XW];

  // Cell RAM access for each state.
  always_comb begin
    cell_we    = 1'b0;
    cell_addr  = cur_idx;
    cell_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        cell_we   = 1'b1;
        cell_addr = clr_cnt_q;
      end
      S_START: begin
        cell_we            = 1'b1;
        cell_wdata.visited = 1'b1;
      end
      S_IDLE: begin
        if (action_e'(action_i) == ActRead) begin
          cell_addr = {YW'(cell_y_i), XW'(cell_x_i)};
        end
      end
      S_SCAN: begin
        if (rd_idx_q < 3'd4) begin
          cell_addr = nbr_idx[rd_idx_q[1:0]];
        end
      end
      S_DECIDE: begin
        if (found) begin
          cell_we         = 1'b1;
          cell_wdata      = cell_rdata_q;
          cell_wdata.pass = cell_rdata_q.pass | here_mask(pick);
        end
      end
      S_CARVE: begin
        cell_we            = 1'b1;
        cell_addr          = {ny, nx};
        cell_wdata.visited = 1'b1;
        cell_wdata.pass    = nbr_q[dir_q].pass | there_mask(dir_q);
      end
      S_POP_RD: begin
        cell_addr = stack_rdata_q;
      end
      default: begin
        cell_addr = cur_idx;
      end
    endcase
  end

  // Path stack access for each state.
  always_comb begin
    stack_we    = 1'b0;
    stack_addr  = top_dec2[StackAw-1:0];
    stack_wdata = cur_idx;
    case (state_q)
      S_START: begin
        stack_we   = 1'b1;
        stack_addr = '0;
      end
      S_CARVE: begin
        stack_we    = push_ok;
        stack_addr  = top_q[StackAw-1:0];
        stack_wdata = {ny, nx};
      end
      default: begin
        stack_we = 1'b0;
      end
    endcase
  end

  // Cell RAM, read-first, registered read.
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= cell_wdata;
    end
    cell_rdata_q <= cell_mem[cell_addr];
  end

  // Path stack RAM.
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_addr] <= stack_wdata;
    end
    stack_rdata_q <= stack_mem[stack_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GridWidthReset;
      grid_h_q <= GridHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegGridWidth:  grid_w_q <= cfg_wdata_i;
        RegGridHeight: grid_h_q <= cfg_wdata_i;
        default:       grid_w_q <= grid_w_q;
      endcase
    end
  end

  // Sequencer, walk state and result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      start_pend_q <= 1'b0;
      clr_cnt_q    <= '0;
      rd_idx_q     <= '0;
      choice_q     <= DirEast;
      dir_q        <= DirEast;
      rep_kind_q   <= KindRead;
      rep_x_q      <= '0;
      rep_y_q      <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      top_q        <= '0;
      count_q      <= '0;
      done_q       <= 1'b0;
      kind_q       <= KindStarted;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      out_dir_q    <= DirEast;
      pass_q       <= '0;
      vis_q        <= 1'b0;
      ovf_q        <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        nbr_q[k] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + CellAw'(1);
          if (clr_cnt_q == CellAw'(CellCount - 1)) begin
            state_q <= start_pend_q ? S_START : S_IDLE;
          end
        end
        S_START: begin
          start_pend_q <= 1'b0;
          top_q        <= TopW'(1);
          count_q      <= CountW'(1);
          done_q       <= 1'b1;
          kind_q       <= KindStarted;
          pos_x_q      <= CoordW'(cur_x_q);
          pos_y_q      <= CoordW'(cur_y_q);
          out_dir_q    <= DirEast;
          pass_q       <= '0;
          vis_q        <= 1'b1;
          ovf_q        <= 1'b0;
          state_q      <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (action_e'(action_i))
              ActStart: begin
                cur_x_q      <= start_x;
                cur_y_q      <= start_y;
                start_pend_q <= 1'b1;
                clr_cnt_q    <= '0;
                state_q      <= S_CLEAR;
              end
              ActRead: begin
                rep_kind_q <= KindRead;
                rep_x_q    <= XW'(cell_x_i);
                rep_y_q    <= YW'(cell_y_i);
                state_q    <= S_REPORT;
              end
              ActStep: begin
                rep_x_q  <= cur_x_q;
                rep_y_q  <= cur_y_q;
                choice_q <= dir_e'(choice_i);
                rd_idx_q <= '0;
                if (finished) begin
                  rep_kind_q <= KindFinished;
                  state_q    <= S_REPORT;
                end else if (top_q == '0) begin
                  rep_kind_q <= KindBacktracked;
                  state_q    <= S_REPORT;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Data of the previous read lands here.
          if (rd_idx_q != '0) begin
            nbr_q[2'(rd_idx_q - 3'd1)] <= cell_rdata_q;
          end
          rd_idx_q <= rd_idx_q + 3'd1;
          if (rd_idx_q == 3'd4) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (found) begin
            dir_q   <= pick;
            state_q <= S_CARVE;
          end else begin
            top_q <= top_dec;
            if (top_dec != '0) begin
              state_q <= S_POP_RD;
            end else begin
              done_q    <= 1'b1;
              kind_q    <= KindBacktracked;
              pos_x_q   <= CoordW'(cur_x_q);
              pos_y_q   <= CoordW'(cur_y_q);
              out_dir_q <= DirEast;
              pass_q    <= cell_rdata_q.pass;
              vis_q     <= cell_rdata_q.visited;
              ovf_q     <= 1'b0;
              state_q   <= S_IDLE;
            end
          end
        end
        S_CARVE: begin
          cur_x_q   <= nx;
          cur_y_q   <= ny;
          count_q   <= count_q + CountW'(1);
          if (push_ok) begin
            top_q <= top_q + TopW'(1);
          end
          done_q    <= 1'b1;
          kind_q    <= KindCarved;
          pos_x_q   <= CoordW'(nx);
          pos_y_q   <= CoordW'(ny);
          out_dir_q <= dir_q;
          pass_q    <= nbr_q[dir_q].pass | there_mask(dir_q);
          vis_q     <= 1'b1;
          ovf_q     <= !push_ok;
          state_q   <= S_IDLE;
        end
        S_POP_RD: begin
          cur_x_q    <= pop_x;
          cur_y_q    <= pop_y;
          rep_x_q    <= pop_x;
          rep_y_q    <= pop_y;
          rep_kind_q <= KindBacktracked;
          state_q    <= S_REPORT;
        end
        S_REPORT: begin
          done_q    <= 1'b1;
          kind_q    <= rep_kind_q;
          pos_x_q   <= CoordW'(rep_x_q);
          pos_y_q   <= CoordW'(rep_y_q);
          out_dir_q <= DirEast;
          pass_q    <= cell_rdata_q.pass;
          vis_q     <= cell_rdata_q.visited;
          ovf_q     <= 1'b0;
          state_q   <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o           = done_q;
  assign kind_o           = kind_q;
  assign pos_x_o          = pos_x_q;
  assign pos_y_o          = pos_y_q;
  assign direction_o      = out_dir_q;
  assign passages_o       = pass_q;
  assign cell_visited_o   = vis_q;
  assign stack_overflow_o = ovf_q;

endmodule

FILE: tb/sv/maze_walk_checker.sv
// Predictor and scoreboard for the maze backtracker's command and result channels.
`timescale 1ns / 1ps

module maze_walk_checker
  import mbt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        action_i,
  input  logic [CoordW-1:0] cell_x_i,
  input  logic [CoordW-1:0] cell_y_i,
  input  logic [1:0]        choice_i,
  input  logic              done_i,
  input  logic [2:0]        kind_i,
  input  logic [CoordW-1:0] pos_x_i,
  input  logic [CoordW-1:0] pos_y_i,
  input  logic [1:0]        direction_i,
  input  logic [3:0]        passages_i,
  input  logic              cell_visited_i,
  input  logic              stack_overflow_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);

  // One result word as the block should report it.
  typedef struct packed {
    kind_e             kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    dir_e              dir;
    logic [3:0]        pass;
    logic              visited;
    logic              ovf;
  } walk_word_t;

  // Shadow copy of the maze, the path and the grid registers.
  cell_t             maze_cells [CellCount];
  logic [CellAw-1:0] path_mem [StackDepth];
  int                path_depth;
  int                col;
  int                row;
  int                visit_total;
  logic [CfgW-1:0]   width_reg;
  logic [CfgW-1:0]   height_reg;
  walk_word_t        expected_q [$];
  int                fails;
  int                checked;

  // Grid size in use: zero counts as one, large values saturate.
  function automatic int grid_span(logic [CfgW-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Builds the word reported for one cell.
  function automatic walk_word_t report(kind_e k, int x, int y, dir_e d, logic ovf);
    walk_word_t w;
    cell_t      c;
    c = maze_cells[y * MaxWidth + x];
    w.kind    = k;
    w.x       = CoordW'(x);
    w.y       = CoordW'(y);
    w.dir     = d;
    w.pass    = c.pass;
    w.visited = c.visited;
    w.ovf     = ovf;
    return w;
  endfunction

  // Applies one accepted command to the shadow maze and queues its result.
  task automatic advance_walk(action_e act, int ix, int iy, int pick);
    int         gw;
    int         gh;
    int         nx [4];
    int         ny [4];
    int         k;
    int         d;
    int         here;
    int         there;
    int         e;
    bit         free_side [4];
    logic [3:0] near_bit;
    logic [3:0] far_bit;
    logic       ovf;
    gw = grid_span(width_reg, MaxWidth);
    gh = grid_span(height_reg, MaxHeight);
    case (act)
      ActStart: begin
        foreach (maze_cells[i]) maze_cells[i] = '0;
        col = (ix < gw) ? ix : gw - 1;
        row = (iy < gh) ? iy : gh - 1;
        maze_cells[row * MaxWidth + col].visited = 1'b1;
        path_mem[0] = CellAw'(row * MaxWidth + col);
        path_depth  = 1;
        visit_total = 1;
        expected_q.push_back(report(KindStarted, col, row, DirEast, 1'b0));
      end
      ActRead: begin
        expected_q.push_back(report(KindRead, ix, iy, DirEast, 1'b0));
      end
      ActStep: begin
        if (visit_total >= gw * gh) begin
          expected_q.push_back(report(KindFinished, col, row, DirEast, 1'b0));
        end else if (path_depth == 0) begin
          expected_q.push_back(report(KindBacktracked, col, row, DirEast, 1'b0));
        end else begin
          nx = '{col + 1, col - 1, col, col};
          ny = '{row, row, row + 1, row - 1};
          free_side[0] = (col + 1 < gw);
          free_side[1] = (col >= 1) && (col - 1 < gw);
          free_side[2] = (row + 1 < gh);
          free_side[3] = (row >= 1) && (row - 1 < gh);
          for (k = 0; k < 4; k++) begin
            if (free_side[k] && maze_cells[ny[k] * MaxWidth + nx[k]].visited) begin
              free_side[k] = 1'b0;
            end
          end
          // First free side at or after the random choice, cyclically.
          d = -1;
          for (k = 0; k < 4; k++) begin
            if (d < 0 && free_side[(pick + k) % 4]) d = (pick + k) % 4;
          end
          if (d >= 0) begin
            near_bit = 4'b0001 << d;
            far_bit  = 4'b0001 << (d ^ 1);
            here     = row * MaxWidth + col;
            there    = ny[d] * MaxWidth + nx[d];
            maze_cells[here].pass    |= near_bit;
            maze_cells[there].pass   |= far_bit;
            maze_cells[there].visited = 1'b1;
            col = nx[d];
            row = ny[d];
            visit_total++;
            ovf = 1'b0;
            if (path_depth < StackDepth) begin
              path_mem[path_depth] = CellAw'(there);
              path_depth++;
            end else begin
              ovf = 1'b1;
            end
            expected_q.push_back(report(KindCarved, col, row, dir_e'(d), ovf));
          end else begin
            // Dead end: drop the current cell and return to the one below it.
            path_depth--;
            if (path_depth > 0) begin
              e   = int'(path_mem[path_depth - 1]);
              col = e % MaxWidth;
              row = (e / MaxWidth) % MaxHeight;
            end
            expected_q.push_back(report(KindBacktracked, col, row, DirEast, 1'b0));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Results are compared first, then register writes and new commands apply.
  always @(posedge clk_i or negedge rst_ni) begin
    walk_word_t exp_word;
    if (!rst_ni) begin
      foreach (maze_cells[i]) maze_cells[i] = '0;
      path_depth  = 0;
      col         = 0;
      row         = 0;
      visit_total = 0;
      width_reg   = GridWidthReset;
      height_reg  = GridHeightReset;
      expected_q.delete();
      fails       = 0;
      checked     = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("[%0t] result word with nothing expected: kind %0d pos (%0d,%0d)",
                     $time, kind_i, pos_x_i, pos_y_i);
          end
        end else begin
          exp_word = expected_q.pop_front();
          checked++;
          if (kind_i !== exp_word.kind || pos_x_i !== exp_word.x ||
              pos_y_i !== exp_word.y || direction_i !== exp_word.dir ||
              passages_i !== exp_word.pass || cell_visited_i !== exp_word.visited ||
              stack_overflow_i !== exp_word.ovf) begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] mismatch: expected kind %0d pos (%0d,%0d) dir %0d pass %b vis %b ovf %b",
                       $time, exp_word.kind, exp_word.x, exp_word.y, exp_word.dir,
                       exp_word.pass, exp_word.visited, exp_word.ovf);
              $display("             got      kind %0d pos (%0d,%0d) dir %0d pass %b vis %b ovf %b",
                       kind_i, pos_x_i, pos_y_i, direction_i, passages_i, cell_visited_i,
                       stack_overflow_i);
            end
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == RegGridWidth) begin
          width_reg = cfg_wdata_i;
        end else begin
          height_reg = cfg_wdata_i;
        end
      end
      if (start_i && !busy_i) begin
        advance_walk(action_e'(action_i), int'(cell_x_i), int'(cell_y_i), int'(choice_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
  end

endmodule

FILE: tb/sv/tb_maze_backtracker_step.sv
// Testbench top for the maze backtracker: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_maze_backtracker_step;
  import mbt_pkg::*;

  localparam int ItemTarget = 1300;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic              cfg_addr  = RegGridWidth;
  logic [CfgW-1:0]   cfg_wdata = '0;
  logic              start     = 1'b0;
  logic [1:0]        action    = ActNone;
  logic [CoordW-1:0] cell_x    = '0;
  logic [CoordW-1:0] cell_y    = '0;
  logic [1:0]        choice    = '0;
  logic              busy;
  logic              done;
  logic [2:0]        kind;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic [1:0]        direction;
  logic [3:0]        passages;
  logic              cell_visited;
  logic              stack_overflow;
  int                error_count;
  int                pending_words;
  int                checked_words;

  // Stimulus bookkeeping.
  int items_sent  = 0;
  int starts_sent = 0;
  int steps_sent  = 0;
  int reads_sent  = 0;
  int settings    = 0;
  int width_set   = 20;
  int height_set  = 10;

  always #6 clk = ~clk;

  maze_backtracker_step DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .start_i         (start),
    .busy_o          (busy),
    .action_i        (action),
    .cell_x_i        (cell_x),
    .cell_y_i        (cell_y),
    .choice_i        (choice),
    .done_o          (done),
    .kind_o          (kind),
    .pos_x_o         (pos_x),
    .pos_y_o         (pos_y),
    .direction_o     (direction),
    .passages_o      (passages),
    .cell_visited_o  (cell_visited),
    .stack_overflow_o(stack_overflow)
  );

  maze_walk_checker u_walk_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .start_i         (start),
    .busy_i          (busy),
    .action_i        (action),
    .cell_x_i        (cell_x),
    .cell_y_i        (cell_y),
    .choice_i        (choice),
    .done_i          (done),
    .kind_i          (kind),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .direction_i     (direction),
    .passages_i      (passages),
    .cell_visited_i  (cell_visited),
    .stack_overflow_i(stack_overflow),
    .fail_count_o    (error_count),
    .pending_o       (pending_words),
    .checked_o       (checked_words)
  );

  // Grid size the block will use for a register value.
  function automatic int used_span(int v);
    if (v == 0) return 1;
    return (v > 32) ? 32 : v;
  endfunction

  // Random register value, biased to small grids with the extremes mixed in.
  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return $urandom_range(33, 63);
    if (r < 22) return 32;
    if (r < 26) return 63;
    return $urandom_range(1, 8);
  endfunction

  // Sends one command word; called at a falling edge, returns at the falling
  // edge after it was taken with start still high.
  task automatic send_word(action_e act, int x, int y, int pick);
    bit idle_on;
    idle_on = !(items_sent >= 500 && items_sent < 800);
    while (idle_on && $urandom_range(0, 99) < 29) begin
      start  <= 1'b0;
      action <= action_e'($urandom_range(0, 3));
      cell_x <= CoordW'($urandom_range(0, 31));
      cell_y <= CoordW'($urandom_range(0, 31));
      choice <= 2'($urandom_range(0, 3));
      @(negedge clk);
    end
    start  <= 1'b1;
    action <= act;
    cell_x <= CoordW'(x);
    cell_y <= CoordW'(y);
    choice <= 2'(pick);
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    case (act)
      ActStart: starts_sent++;
      ActStep:  steps_sent++;
      ActRead:  reads_sent++;
      default: begin
      end
    endcase
    if (act != ActNone) items_sent++;
  endtask

  // Drops start and waits until the block is idle with nothing outstanding.
  task automatic settle();
    start <= 1'b0;
    while (pending_words != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes both grid registers; called at a falling edge while idle.
  task automatic set_grid(int w, int h);
    cfg_we    <= 1'b1;
    cfg_addr  <= RegGridWidth;
    cfg_wdata <= CfgW'(w);
    @(negedge clk);
    cfg_addr  <= RegGridHeight;
    cfg_wdata <= CfgW'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    width_set  = w;
    height_set = h;
    settings++;
  endtask

  // Run limit, far above the slowest correct run.
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int phase;
    int sw;
    int sh;
    int run_len;
    int n;
    int r;
    int drain;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // The post-reset clearing sweep holds busy high.
    settle();

    // Directed: step and reads before any start, ignored action, clamped start.
    send_word(ActStep, 0, 0, DirEast);
    send_word(ActRead, 31, 31, DirEast);
    send_word(ActRead, 0, 0, DirEast);
    send_word(ActNone, 0, 0, DirEast);
    send_word(ActStart, 31, 31, DirEast);
    send_word(ActStep, 0, 0, DirNorth);
    send_word(ActStep, 0, 0, DirWest);
    send_word(ActStep, 0, 0, DirSouth);
    send_word(ActStep, 0, 0, DirEast);
    send_word(ActRead, 19, 9, DirEast);

    // Zero registers mean a one-cell grid: the start finishes the maze.
    settle();
    set_grid(0, 0);
    send_word(ActStart, 7, 21, DirEast);
    send_word(ActStep, 0, 0, DirSouth);
    send_word(ActRead, 0, 0, DirEast);

    // One column of three: carve north, dead end, back, carve south, done.
    settle();
    set_grid(1, 3);
    send_word(ActStart, 0, 1, DirEast);
    send_word(ActStep, 0, 0, DirNorth);
    send_word(ActStep, 0, 0, DirEast);
    send_word(ActStep, 0, 0, DirSouth);
    send_word(ActStep, 0, 0, DirWest);
    send_word(ActRead, 0, 1, DirEast);

    // Random walks; some phases resize the grid and carry on without a start.
    phase = 0;
    while (items_sent < ItemTarget) begin
      settle();
      case (phase)
        0:       set_grid(63, 63);
        1:       set_grid(32, 32);
        2:       set_grid(1, 32);
        3:       set_grid(32, 1);
        default: set_grid(pick_span(), pick_span());
      endcase
      sw      = used_span(width_set);
      sh      = used_span(height_set);
      run_len = (2 * sw * sh + 8 > 70) ? 70 : 2 * sw * sh + 8;
      if (phase < 4 || $urandom_range(0, 99) < 85) begin
        send_word(ActStart, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 3));
      end
      for (n = 0; n < run_len && items_sent < ItemTarget; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_word(ActStep, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 3));
        end else if (r < 92) begin
          if ($urandom_range(0, 3) != 0) begin
            send_word(ActRead, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                      $urandom_range(0, 3));
          end else begin
            send_word(ActRead, $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 3));
          end
        end else if (r < 96) begin
          send_word(ActNone, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 3));
        end else begin
          send_word(ActStart, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 3));
        end
      end
      phase++;
    end

    // Drain outstanding results, then let the block's own latency pass.
    start <= 1'b0;
    drain = 0;
    while (pending_words != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (16) @(negedge clk);

    $display("Sent %0d command words (%0d starts, %0d steps, %0d reads) over %0d grid settings.",
             items_sent, starts_sent, steps_sent, reads_sent, settings);
    $display("Compared %0d result words; %0d mismatches, %0d results never arrived.",
             checked_words, error_count, pending_words);
    if (error_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
